@@ rtl/m3i_pkg.sv @@
// ----------------------------------------------------------------------------
// m3i_pkg: shared types and constants for the 3x3 matrix inverse
// Payload structs, pipeline bus structs, widths, latencies and helpers.
// ----------------------------------------------------------------------------
package m3i_pkg;

  typedef struct packed {
    logic signed [31:0] a00;
    logic signed [31:0] a01;
    logic signed [31:0] a02;
    logic signed [31:0] a10;
    logic signed [31:0] a11;
    logic signed [31:0] a12;
    logic signed [31:0] a20;
    logic signed [31:0] a21;
    logic signed [31:0] a22;
  } in_t;

  typedef struct packed {
    logic signed [31:0] b00;
    logic signed [31:0] b01;
    logic signed [31:0] b02;
    logic signed [31:0] b10;
    logic signed [31:0] b11;
    logic signed [31:0] b12;
    logic signed [31:0] b20;
    logic signed [31:0] b21;
    logic signed [31:0] b22;
    logic               singular;
    logic               saturated;
  } out_t;

  // Element k is row k/3, column k%3.
  typedef logic [8:0][31:0] mat_t;

  localparam int unsigned COF_W  = 64;  // cofactor, Q32.32, wraps at 64 bits
  localparam int unsigned TERM_W = 97;  // signed cofactor times element
  localparam int unsigned DET_W  = 99;  // signed sum of three terms
  localparam int unsigned DMAG_W = 96;  // determinant magnitude
  localparam int unsigned DIV_W  = DMAG_W + 1;      // divisor 2*|det|
  localparam int unsigned NUM_W  = DIV_W + 1;       // 2*|c|*2^32 + |det|
  localparam int unsigned Q_W    = 32;              // quotient bits formed

  localparam int unsigned COF_LAT   = 3;
  localparam int unsigned DET_LAT   = 4;
  localparam int unsigned DIV_LAT   = Q_W + 3;
  localparam int unsigned TOTAL_LAT = COF_LAT + DET_LAT + DIV_LAT;

  // Cofactor k = m[PA[k]]*m[PB[k]] - m[QA[k]]*m[QB[k]].
  localparam logic [3:0] PA_IDX [9] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
  localparam logic [3:0] PB_IDX [9] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
  localparam logic [3:0] QA_IDX [9] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
  localparam logic [3:0] QB_IDX [9] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

  typedef struct packed {
    mat_t                 mat;
    logic [8:0][COF_W-1:0] cof;
  } cof_bus_t;

  typedef struct packed {
    mat_t                  mat;
    logic [8:0][COF_W-1:0] cmag;
    logic [8:0]            cneg;
    logic [DMAG_W-1:0]     dmag;
    logic                  dneg;
    logic                  singular;
  } det_bus_t;

  typedef struct packed {
    logic valid;
    logic singular;
  } ctl_t;

  function automatic mat_t mat_of(in_t x);
    mat_of = {x.a22, x.a21, x.a20, x.a12, x.a11, x.a10, x.a02, x.a01, x.a00};
  endfunction

  function automatic out_t pack_out(mat_t b, logic sing, logic sat);
    out_t o;
    o.b00 = b[0];
    o.b01 = b[1];
    o.b02 = b[2];
    o.b10 = b[3];
    o.b11 = b[4];
    o.b12 = b[5];
    o.b20 = b[6];
    o.b21 = b[7];
    o.b22 = b[8];
    o.singular  = sing;
    o.saturated = sat;
    pack_out = o;
  endfunction

  function automatic logic [31:0] mag32(logic [31:0] x);
    mag32 = x[31] ? (32'd0 - x) : x;
  endfunction

  function automatic logic [63:0] mag64(logic [63:0] x);
    mag64 = x[63] ? (64'd0 - x) : x;
  endfunction

endpackage

@@ rtl/m3i_cofactor.sv @@
// ----------------------------------------------------------------------------
// m3i_cofactor: adjugate cofactors
// Input register, eighteen 32x32 signed products, then nine differences.
// ----------------------------------------------------------------------------
module m3i_cofactor (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  input  m3i_pkg::in_t      data_i,
  output logic              valid_o,
  output m3i_pkg::cof_bus_t bus_o
);

  logic [2:0]          vld_r;
  m3i_pkg::mat_t       in_r;
  m3i_pkg::mat_t       mat2_r;
  logic signed [63:0]  pp_r [9];
  logic signed [63:0]  qp_r [9];
  m3i_pkg::cof_bus_t   bus_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    in_r   <= m3i_pkg::mat_of(data_i);
    mat2_r <= in_r;
    bus_r.mat <= mat2_r;
  end

  for (genvar k = 0; k < 9; k++) begin : g_cof
    logic signed [31:0] pa, pb, qa, qb;
    assign pa = in_r[m3i_pkg::PA_IDX[k]];
    assign pb = in_r[m3i_pkg::PB_IDX[k]];
    assign qa = in_r[m3i_pkg::QA_IDX[k]];
    assign qb = in_r[m3i_pkg::QB_IDX[k]];

    always_ff @(posedge clk) begin
      pp_r[k] <= 64'(pa) * 64'(pb);
      qp_r[k] <= 64'(qa) * 64'(qb);
      // The difference wraps at 64 bits.
      bus_r.cof[k] <= pp_r[k] - qp_r[k];
    end
  end

  assign valid_o = vld_r[2];
  assign bus_o   = bus_r;

endmodule

@@ rtl/m3i_det.sv @@
// ----------------------------------------------------------------------------
// m3i_det: determinant from the first row and its cofactors
// Split 64x32 products, signed terms, three-way sum, then magnitude and sign.
// ----------------------------------------------------------------------------
module m3i_det (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  input  m3i_pkg::cof_bus_t bus_i,
  output logic              valid_o,
  output m3i_pkg::det_bus_t bus_o
);

  localparam int unsigned DW = m3i_pkg::DET_W;
  localparam int unsigned TW = m3i_pkg::TERM_W;

  logic [3:0]                         vld_r;
  logic [63:0]                        pl_r [3];
  logic [63:0]                        ph_r [3];
  logic [2:0]                         sgn_r;
  logic signed [TW-1:0]               term_r [3];
  logic signed [DW-1:0]               det_r;
  m3i_pkg::mat_t                      mat_r [3];
  logic [8:0][m3i_pkg::COF_W-1:0]     cmag_r [3];
  logic [8:0]                         cneg_r [3];
  logic signed [DW-1:0]               det_abs;
  m3i_pkg::det_bus_t                  bus_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], valid_i};
    end
  end

  // Sideband and cofactor magnitudes ride along with the determinant.
  always_ff @(posedge clk) begin
    mat_r[0] <= bus_i.mat;
    mat_r[1] <= mat_r[0];
    mat_r[2] <= mat_r[1];
    cmag_r[1] <= cmag_r[0];
    cmag_r[2] <= cmag_r[1];
    cneg_r[1] <= cneg_r[0];
    cneg_r[2] <= cneg_r[1];
  end

  for (genvar k = 0; k < 9; k++) begin : g_mag
    always_ff @(posedge clk) begin
      cmag_r[0][k] <= m3i_pkg::mag64(bus_i.cof[k]);
      cneg_r[0][k] <= bus_i.cof[k][63];
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_term
    logic [63:0] mc;
    logic [31:0] ma;
    logic [95:0] prod;
    assign mc   = m3i_pkg::mag64(bus_i.cof[3*j]);
    assign ma   = m3i_pkg::mag32(bus_i.mat[j]);
    assign prod = {ph_r[j], 32'd0} + {32'd0, pl_r[j]};

    always_ff @(posedge clk) begin
      pl_r[j]   <= 64'(mc[31:0]) * 64'(ma);
      ph_r[j]   <= 64'(mc[63:32]) * 64'(ma);
      sgn_r[j]  <= bus_i.cof[3*j][63] ^ bus_i.mat[j][31];
      term_r[j] <= sgn_r[j] ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
    end
  end

  always_ff @(posedge clk) begin
    det_r <= DW'(term_r[0]) + DW'(term_r[1]) + DW'(term_r[2]);
  end

  assign det_abs = det_r[DW-1] ? -det_r : det_r;

  always_ff @(posedge clk) begin
    bus_r.mat      <= mat_r[2];
    bus_r.cmag     <= cmag_r[2];
    bus_r.cneg     <= cneg_r[2];
    bus_r.dmag     <= det_abs[m3i_pkg::DMAG_W-1:0];
    bus_r.dneg     <= det_r[DW-1];
    bus_r.singular <= (det_r == '0);
  end

  assign valid_o = vld_r[3];
  assign bus_o   = bus_r;

endmodule

@@ rtl/m3i_divider.sv @@
// ----------------------------------------------------------------------------
// m3i_divider: one inverse element, c / det rounded and saturated
// Pipelined restoring division, one quotient bit per stage.
// ----------------------------------------------------------------------------
module m3i_divider (
  input  logic                        clk,
  input  logic [m3i_pkg::COF_W-1:0]   cmag_i,
  input  logic                        cneg_i,
  input  logic [m3i_pkg::DMAG_W-1:0]  dmag_i,
  input  logic                        dneg_i,
  input  logic                        singular_i,
  input  logic [31:0]                 elem_i,
  output logic [31:0]                 b_o,
  output logic                        sat_o
);

  localparam int unsigned NW = m3i_pkg::NUM_W;
  localparam int unsigned DW = m3i_pkg::DIV_W;
  localparam int unsigned QW = m3i_pkg::Q_W;

  // Prep stage.
  logic [NW-1:0] n_r;
  logic [DW-1:0] d0_r;
  logic          neg0_r, sing0_r;
  logic [31:0]   elem0_r;

  // Division stages, index 0 is the state before the first step.
  logic [DW-1:0] rem_r  [QW+1];
  logic [DW-1:0] dv_r   [QW+1];
  logic [QW-1:0] lo_r   [QW+1];
  logic [QW-1:0] q_r    [QW+1];
  logic          ovf_r  [QW+1];
  logic          neg_r  [QW+1];
  logic          sing_r [QW+1];
  logic [31:0]   elem_r [QW+1];

  logic          sat;
  logic [31:0]   mag;
  logic [31:0]   b_r;
  logic          sat_r;

  // Rounding is folded in: q = floor((2*|c|*2^32 + |det|) / (2*|det|)).
  always_ff @(posedge clk) begin
    n_r     <= {1'b0, cmag_i, 33'd0} + {2'd0, dmag_i};
    d0_r    <= {dmag_i, 1'b0};
    neg0_r  <= cneg_i ^ dneg_i;
    sing0_r <= singular_i;
    elem0_r <= elem_i;
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= DW'(n_r[NW-1:QW]);
    ovf_r[0]  <= DW'(n_r[NW-1:QW]) >= d0_r;
    lo_r[0]   <= n_r[QW-1:0];
    q_r[0]    <= '0;
    dv_r[0]   <= d0_r;
    neg_r[0]  <= neg0_r;
    sing_r[0] <= sing0_r;
    elem_r[0] <= elem0_r;
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;
    assign trial = {rem_r[k], lo_r[k][QW-1]};
    assign diff  = trial - {1'b0, dv_r[k]};
    assign ge    = trial >= {1'b0, dv_r[k]};

    always_ff @(posedge clk) begin
      rem_r[k+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
      q_r[k+1]    <= {q_r[k][QW-2:0], ge};
      lo_r[k+1]   <= {lo_r[k][QW-2:0], 1'b0};
      dv_r[k+1]   <= dv_r[k];
      ovf_r[k+1]  <= ovf_r[k];
      neg_r[k+1]  <= neg_r[k];
      sing_r[k+1] <= sing_r[k];
      elem_r[k+1] <= elem_r[k];
    end
  end

  // The negative limit is one step further out than the positive one.
  assign sat = ovf_r[QW] ||
               (q_r[QW][31] && (!neg_r[QW] || (q_r[QW][30:0] != '0)));
  assign mag = sat ? (neg_r[QW] ? 32'h8000_0000 : 32'h7FFF_FFFF) : q_r[QW];

  always_ff @(posedge clk) begin
    if (sing_r[QW]) begin
      b_r   <= elem_r[QW];
      sat_r <= 1'b0;
    end else begin
      b_r   <= neg_r[QW] ? (32'd0 - mag) : mag;
      sat_r <= sat;
    end
  end

  assign b_o   = b_r;
  assign sat_o = sat_r;

endmodule

@@ rtl/matrix3_inverse.sv @@
// ----------------------------------------------------------------------------
// matrix3_inverse: 3x3 matrix inverse in signed Q16.16
// Adjugate over determinant, rounded to nearest and saturated per element.
// ----------------------------------------------------------------------------
// Usage: drive a row-major matrix on in_data and raise start for one cycle
// per matrix. A transfer happens on every rising edge with start high and
// busy low; busy is always low, so a new matrix may enter every cycle.
// The inverse appears on out_data, with out_valid high for exactly one
// cycle, in the same order, after passing 42 register stages in all.
// The latency is set by the 32 one-bit restoring division stages (with the
// two setup stages and the final saturation stage) behind 3 cofactor and
// 4 determinant stages.
// A zero determinant returns the input matrix with singular set. Any element
// clipped to the 32-bit range sets saturated.
// The receiver cannot stall, so nothing is held back. Synchronous reset
// clears all valid bits; matrices in flight are dropped and no result
// appears until new matrices arrive.
// ----------------------------------------------------------------------------
module matrix3_inverse (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  m3i_pkg::in_t  in_data,
  output logic          out_valid,
  output m3i_pkg::out_t out_data
);

  localparam int unsigned DL = m3i_pkg::DIV_LAT;

  logic              cof_valid;
  m3i_pkg::cof_bus_t cof_bus;
  logic              det_valid;
  m3i_pkg::det_bus_t det_bus;
  m3i_pkg::ctl_t     ctl_r [DL];
  m3i_pkg::mat_t     b_vec;
  logic [8:0]        sat_vec;

  assign busy = 1'b0;

  m3i_cofactor u_cofactor (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (start && !busy),
    .data_i  (in_data),
    .valid_o (cof_valid),
    .bus_o   (cof_bus)
  );

  m3i_det u_det (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (cof_valid),
    .bus_i   (cof_bus),
    .valid_o (det_valid),
    .bus_o   (det_bus)
  );

  for (genvar k = 0; k < 9; k++) begin : g_lane
    m3i_divider u_div (
      .clk        (clk),
      .cmag_i     (det_bus.cmag[k]),
      .cneg_i     (det_bus.cneg[k]),
      .dmag_i     (det_bus.dmag),
      .dneg_i     (det_bus.dneg),
      .singular_i (det_bus.singular),
      .elem_i     (det_bus.mat[k]),
      .b_o        (b_vec[k]),
      .sat_o      (sat_vec[k])
    );
  end

  // Valid and singular follow the division lanes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DL; i++) begin
        ctl_r[i] <= '0;
      end
    end else begin
      ctl_r[0] <= '{valid: det_valid, singular: det_bus.singular};
      for (int i = 1; i < DL; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
    end
  end

  assign out_valid = ctl_r[DL-1].valid;
  assign out_data  = m3i_pkg::pack_out(b_vec, ctl_r[DL-1].singular, |sat_vec);

  a_sing_not_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.singular && out_data.saturated))
    else $error("singular and saturated both set");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, m3i_pkg::TOTAL_LAT))
    else $error("result without a matching input transfer");

  a_sing_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.singular) |->
      (out_data.b00 == $past(in_data.a00, m3i_pkg::TOTAL_LAT)) &&
      (out_data.b22 == $past(in_data.a22, m3i_pkg::TOTAL_LAT)))
    else $error("singular result does not return the input matrix");

endmodule
